FILE: hdl/edt_pkg.sv
// Shared constants for the exact distance transform.
// No dependencies.
package edt_pkg;
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int FRACTION_BITS = 8;
    localparam int XW            = $clog2(MAX_WIDTH);
    localparam int YW            = $clog2(MAX_HEIGHT);
    localparam int AW            = XW + YW;
    localparam int DEPTH         = MAX_WIDTH * MAX_HEIGHT;
    localparam int DW            = 17;
    localparam int RW            = XW + 2;
    localparam logic [RW-1:0] ROW_INF = '1;
    localparam logic [DW-1:0] DIST_LIMIT = '1;
    localparam int SQW           = 2 * (RW + 1) + 2 * FRACTION_BITS;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_METRIC = 2'd2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;
endpackage

FILE: hdl/edt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module edt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/edt_sqrt.sv
// Bit-serial integer square root, consuming two radicand bits per cycle.
// Depends on edt_pkg.
module edt_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [edt_pkg::SQW-1:0]   radicand,
    output logic                      done,
    output logic [edt_pkg::SQW/2-1:0] root
);
    localparam int HW = edt_pkg::SQW / 2;
    localparam int CW = $clog2(HW + 1);

    logic [edt_pkg::SQW-1:0] rem_reg, rem_next;
    logic [edt_pkg::SQW-1:0] rad_reg, rad_next;
    logic [HW-1:0]           root_reg, root_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [edt_pkg::SQW-1:0] trial;
    logic [edt_pkg::SQW-1:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[edt_pkg::SQW-3:0], rad_reg[edt_pkg::SQW-1 -: 2]};
        trial     = {{(edt_pkg::SQW-HW-2){1'b0}}, root_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            rad_next  = radicand;
            root_next = '0;
            cnt_next  = CW'(HW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[edt_pkg::SQW-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[HW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[HW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

FILE: hdl/exact_distance_transform.sv
// Exact distance transform: top level. Depends on edt_pkg, edt_ram, edt_sqrt.
// A read passes from the registered distance-store read through ST_RD into the
// output register. The final write of a frame starts a compute pass: forward
// and backward row passes, then a column search per pixel (Euclidean adds a
// square root per pixel). Reset (rst_n, async) clears positions, control and
// config to 256x256 Euclidean; stores are undefined until written.
module exact_distance_transform (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic        is_foreground,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] distance_q8,
    output logic        no_background,
    output logic        last_of_frame
);
    localparam int AW  = edt_pkg::AW;
    localparam int XW  = edt_pkg::XW;
    localparam int YW  = edt_pkg::YW;
    localparam int RW  = edt_pkg::RW;
    localparam int DW  = edt_pkg::DW;
    localparam int SQW = edt_pkg::SQW;
    localparam int CW  = AW + 1;
    localparam int BW  = SQW;
    localparam int DIST_LIM_SHR = (1 << (DW - edt_pkg::FRACTION_BITS)) - 1;

    // sequencer codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FWD_RD = 4'd1;
    localparam logic [3:0] ST_FWD    = 4'd2;
    localparam logic [3:0] ST_BWD_RD = 4'd3;
    localparam logic [3:0] ST_BWD    = 4'd4;
    localparam logic [3:0] ST_COL_RD = 4'd5;
    localparam logic [3:0] ST_COL    = 4'd6;
    localparam logic [3:0] ST_FIN    = 4'd7;
    localparam logic [3:0] ST_WAIT   = 4'd9;
    localparam logic [3:0] ST_STORE  = 4'd10;
    localparam logic [3:0] ST_RD     = 4'd11;

    // configuration
    logic [8:0] width_reg, height_reg;
    logic       metric_reg;
    logic       cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            edt_pkg::REG_WIDTH:  prdata = {23'd0, width_reg};
            edt_pkg::REG_HEIGHT: prdata = {23'd0, height_reg};
            edt_pkg::REG_METRIC: prdata = {31'd0, metric_reg};
            default:             prdata = '0;
        endcase
    end

    // clamped frame size
    logic [XW:0] w_eff;
    logic [YW:0] h_eff;
    logic [CW-1:0] count;
    assign w_eff = (width_reg == 9'd0) ? (XW+1)'(1) :
                   (width_reg > 9'(edt_pkg::MAX_WIDTH)) ? (XW+1)'(edt_pkg::MAX_WIDTH) :
                   (XW+1)'(width_reg);
    assign h_eff = (height_reg == 9'd0) ? (YW+1)'(1) :
                   (height_reg > 9'(edt_pkg::MAX_HEIGHT)) ? (YW+1)'(edt_pkg::MAX_HEIGHT) :
                   (YW+1)'(height_reg);
    assign count = CW'(w_eff) * CW'(h_eff);

    // state
    logic [3:0]    st_reg, st_next;
    logic [CW-1:0] load_reg, load_next, rdp_reg, rdp_next;
    logic [XW:0]   x_reg, x_next;
    logic [YW:0]   y_reg, y_next, yy_reg, yy_next;
    logic [RW-1:0] run_reg, run_next;
    logic          anybg_reg, anybg_next;
    logic [BW-1:0] best_reg, best_next;
    logic          ov_reg, ov_next;
    logic [DW-1:0] od_reg, od_next;
    logic          onb_reg, onb_next;
    logic          olast_reg, olast_next;
    logic          rlast_reg, rlast_next;

    // memories: each row-store entry holds {pixel, row distance}
    logic          row_we;
    logic [AW-1:0] row_wa, row_ra;
    logic [RW:0]   row_wd, row_rd;
    logic          pix_rd;
    logic [RW-1:0] gdist;
    logic          dst_we;
    logic [AW-1:0] dst_wa, dst_ra;
    logic [DW:0]   dst_wd, dst_rd;

    edt_ram #(.WIDTH(RW+1), .DEPTH(edt_pkg::DEPTH)) u_row (
        .clk(clk), .we(row_we), .waddr(row_wa), .wdata(row_wd),
        .raddr(row_ra), .rdata(row_rd));
    edt_ram #(.WIDTH(DW+1), .DEPTH(edt_pkg::DEPTH)) u_dst (
        .clk(clk), .we(dst_we), .waddr(dst_wa), .wdata(dst_wd),
        .raddr(dst_ra), .rdata(dst_rd));

    assign pix_rd = row_rd[RW];
    assign gdist  = row_rd[RW-1:0];

    // square root
    logic          sq_start, sq_done;
    logic [SQW/2-1:0] sq_root;
    edt_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .radicand(best_reg << (2 * edt_pkg::FRACTION_BITS)),
        .done(sq_done), .root(sq_root));

    // addressing helpers
    logic [AW-1:0] addr_xy, addr_xyy;
    assign addr_xy  = AW'(y_reg) * AW'(w_eff) + AW'(x_reg);
    assign addr_xyy = AW'(yy_reg) * AW'(w_eff) + AW'(x_reg);

    // candidate for the column search
    logic [YW:0]     dy;
    logic [2*RW-1:0] dy_sq, g_sq;
    logic [BW-1:0]   cand;
    logic [DW-1:0]   q_man;
    assign dy    = (yy_reg > y_reg) ? (yy_reg - y_reg) : (y_reg - yy_reg);
    assign dy_sq = (2*RW)'(dy) * (2*RW)'(dy);
    assign g_sq  = (2*RW)'(gdist) * (2*RW)'(gdist);
    assign cand  = metric_reg ? BW'(dy) + BW'(gdist) : BW'(dy_sq) + BW'(g_sq);
    assign q_man = (best_reg > BW'(DIST_LIM_SHR)) ? edt_pkg::DIST_LIMIT :
                   DW'(best_reg << edt_pkg::FRACTION_BITS);

    logic in_acc, out_acc, slot_free;
    assign out_acc   = out_valid && out_ready;
    assign slot_free = !ov_reg || out_ready;
    assign in_ready  = (st_reg == ST_IDLE) && slot_free;
    assign in_acc    = in_valid && in_ready;

    always_comb
    begin
        st_next    = st_reg;
        load_next  = load_reg;
        rdp_next   = rdp_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        yy_next    = yy_reg;
        run_next   = run_reg;
        anybg_next = anybg_reg;
        best_next  = best_reg;
        ov_next    = out_acc ? 1'b0 : ov_reg;
        od_next    = od_reg;
        onb_next   = onb_reg;
        olast_next = olast_reg;
        rlast_next = rlast_reg;
        row_we = 1'b0; row_wa = addr_xy; row_wd = {pix_rd, run_reg}; row_ra = addr_xyy;
        dst_we = 1'b0; dst_wa = addr_xy; dst_wd = '0; dst_ra = '0;
        sq_start = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_acc && mode == edt_pkg::MODE_WRITE)
                begin
                    // drop out-of-range positions back to the first pixel
                    row_we = 1'b1;
                    row_wa = (load_reg >= count) ? '0 : AW'(load_reg);
                    row_wd = {is_foreground, edt_pkg::ROW_INF};
                    load_next = ((load_reg >= count) ? CW'(0) : load_reg) + 1'b1;
                    if (((load_reg >= count) ? CW'(1) : load_reg + 1'b1) >= count)
                    begin
                        load_next  = '0;
                        rdp_next   = '0;
                        x_next     = '0;
                        y_next     = '0;
                        anybg_next = 1'b0;
                        run_next   = edt_pkg::ROW_INF;
                        st_next    = ST_FWD_RD;
                    end
                end
                else if (in_acc)
                begin
                    dst_ra     = (rdp_reg >= count) ? '0 : AW'(rdp_reg);
                    rlast_next = (((rdp_reg >= count) ? CW'(0) : rdp_reg) + 1'b1) == count;
                    rdp_next   = (((rdp_reg >= count) ? CW'(0) : rdp_reg) + 1'b1 >= count) ?
                                 '0 : ((rdp_reg >= count) ? CW'(0) : rdp_reg) + 1'b1;
                    st_next    = ST_RD;
                end
            end
            ST_RD:
            begin
                // read data arrives; load output register
                ov_next    = 1'b1;
                od_next    = dst_rd[DW-1:0];
                onb_next   = dst_rd[DW];
                olast_next = rlast_reg;
                st_next    = ST_IDLE;
            end
            ST_FWD_RD:
            begin
                row_ra  = addr_xy;
                st_next = ST_FWD;
            end
            ST_FWD:
            begin
                // left-to-right run length
                row_we = 1'b1;
                if (!pix_rd)
                begin
                    row_wd = {pix_rd, RW'(0)}; run_next = '0; anybg_next = 1'b1;
                end
                else
                begin
                    run_next = (run_reg == edt_pkg::ROW_INF) ? run_reg : run_reg + 1'b1;
                    row_wd   = {pix_rd, run_next};
                end
                if (x_reg == w_eff - 1'b1)
                begin
                    run_next = edt_pkg::ROW_INF;
                    st_next  = ST_BWD_RD;
                end
                else
                begin
                    x_next  = x_reg + 1'b1;
                    st_next = ST_FWD_RD;
                end
            end
            ST_BWD_RD:
            begin
                row_ra  = addr_xy;
                yy_next = y_reg;
                st_next = ST_BWD;
            end
            ST_BWD:
            begin
                if (!pix_rd)
                begin
                    run_next = '0;
                end
                else
                begin
                    run_next = (run_reg == edt_pkg::ROW_INF) ? run_reg : run_reg + 1'b1;
                end
                if (run_next < gdist)
                begin
                    row_we = 1'b1;
                    row_wd = {pix_rd, run_next};
                end
                if (x_reg == '0)
                begin
                    run_next = edt_pkg::ROW_INF;
                    if (y_reg == h_eff - 1'b1)
                    begin
                        y_next    = '0;
                        yy_next   = '0;
                        best_next = '1;
                        st_next   = ST_COL_RD;
                    end
                    else
                    begin
                        y_next  = y_reg + 1'b1;
                        st_next = ST_FWD_RD;
                    end
                end
                else
                begin
                    x_next  = x_reg - 1'b1;
                    st_next = ST_BWD_RD;
                end
            end
            ST_COL_RD:
                st_next = ST_COL;
            ST_COL:
            begin
                if (gdist != edt_pkg::ROW_INF && cand < best_reg)
                begin
                    best_next = cand;
                end
                if (yy_reg == h_eff - 1'b1)
                begin
                    st_next = ST_FIN;
                end
                else
                begin
                    yy_next = yy_reg + 1'b1;
                    st_next = ST_COL_RD;
                end
            end
            ST_FIN:
            begin
                if (!anybg_reg)
                begin
                    dst_we = 1'b1;
                    dst_wd = {1'b1, edt_pkg::DIST_LIMIT};
                    st_next = ST_STORE;
                end
                else if (metric_reg)
                begin
                    dst_we = 1'b1;
                    dst_wd = {1'b0, q_man};
                    st_next = ST_STORE;
                end
                else
                begin
                    sq_start = 1'b1;
                    st_next  = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sq_done)
                begin
                    dst_we = 1'b1;
                    dst_wd = {1'b0, (sq_root > (SQW/2)'(edt_pkg::DIST_LIMIT)) ?
                              edt_pkg::DIST_LIMIT : DW'(sq_root)};
                    st_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                // advance to the next pixel of the column pass
                yy_next   = '0;
                best_next = '1;
                st_next   = ST_COL_RD;
                if (x_reg == w_eff - 1'b1)
                begin
                    x_next = '0;
                    if (y_reg == h_eff - 1'b1)
                    begin
                        y_next  = '0;
                        st_next = ST_IDLE;
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            default:
                st_next = ST_IDLE;
        endcase
        if (cfg_wr && (paddr[3:2] == edt_pkg::REG_WIDTH || paddr[3:2] == edt_pkg::REG_HEIGHT))
        begin
            load_next = '0;
            rdp_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            load_reg   <= '0;
            rdp_reg    <= '0;
            ov_reg     <= 1'b0;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            metric_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            load_reg <= load_next;
            rdp_reg  <= rdp_next;
            ov_reg   <= ov_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    edt_pkg::REG_WIDTH:  width_reg  <= pwdata[8:0];
                    edt_pkg::REG_HEIGHT: height_reg <= pwdata[8:0];
                    edt_pkg::REG_METRIC: metric_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        yy_reg    <= yy_next;
        run_reg   <= run_next;
        anybg_reg <= anybg_next;
        best_reg  <= best_next;
        od_reg    <= od_next;
        onb_reg   <= onb_next;
        olast_reg <= olast_next;
        rlast_reg <= rlast_next;
    end

    assign out_valid     = ov_reg;
    assign distance_q8   = od_reg;
    assign no_background = onb_reg;
    assign last_of_frame = olast_reg;

    // an item is never taken while the sequencer is busy
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> st_reg == ST_IDLE) else $error("accept while busy");
    // a read result reaches the output register by way of the ST_RD state
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && mode == edt_pkg::MODE_READ) |=> ##1 out_valid)
        else $error("read result missing");
    // the output register never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(distance_q8))
        else $error("result overwritten");
endmodule

FILE: verif/tb.sv
// Self-checking testbench for exact_distance_transform: APB setup, frame loads
// and result reads, checked against a behavioral distance predictor.
// Depends on edt_pkg and the exact_distance_transform RTL.
module tb;
    typedef struct {
        logic [16:0] distance;
        logic        nobg;
        logic        last;
    } dist_result_t;

    // Predictor and scoreboard: mirrors the block's stores and positions, and
    // keeps the queue of distances that reads have asked for.
    class distance_oracle;
        bit          pix[edt_pkg::DEPTH];
        int unsigned dstore[edt_pkg::DEPTH];
        bit          dvalid[edt_pkg::DEPTH];
        int          rowd[edt_pkg::DEPTH];
        int unsigned load_pos;
        int unsigned read_pos;
        int unsigned width_reg;
        int unsigned height_reg;
        bit          manhattan;
        bit          computing;
        int          errors;
        dist_result_t pending_distances[$];

        function new();
            load_pos   = 0;
            read_pos   = 0;
            width_reg  = 256;
            height_reg = 256;
            manhattan  = 0;
            computing  = 0;
            errors     = 0;
        endfunction

        function int unsigned eff_w();
            if (width_reg < 1) return 1;
            if (width_reg > edt_pkg::MAX_WIDTH) return edt_pkg::MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg < 1) return 1;
            if (height_reg > edt_pkg::MAX_HEIGHT) return edt_pkg::MAX_HEIGHT;
            return height_reg;
        endfunction

        function int unsigned pixel_count();
            return eff_w() * eff_h();
        endfunction

        // Cycles the block may still be busy after the final write of a frame.
        function int unsigned settle_cycles();
            int unsigned n;
            n = pixel_count();
            return 2 * n + n * (2 * eff_h() + 1) + 25 * n + 64;
        endfunction

        function bit can_read();
            int unsigned p;
            p = (read_pos >= pixel_count()) ? 0 : read_pos;
            return dvalid[p];
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                edt_pkg::REG_WIDTH:
                begin
                    width_reg = val & 'h1FF;
                    load_pos  = 0;
                    read_pos  = 0;
                end
                edt_pkg::REG_HEIGHT:
                begin
                    height_reg = val & 'h1FF;
                    load_pos   = 0;
                    read_pos   = 0;
                end
                edt_pkg::REG_METRIC: manhattan = val[0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root, probe;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > v) probe >>= 2;
            while (probe != 0)
            begin
                if (v >= root + probe)
                begin
                    v    -= root + probe;
                    root  = (root >> 1) + probe;
                end
                else
                    root >>= 1;
                probe >>= 2;
            end
            return root;
        endfunction

        // Brute-force transform: row distances, then exact minimum over rows.
        function void transform_frame();
            int unsigned w, h, base;
            int run;
            bit any_bg;
            longint unsigned best, cand, dy, q;
            w = eff_w();
            h = eff_h();
            any_bg = 0;
            for (int y = 0; y < h; y++)
            begin
                base = y * w;
                run = -1;
                for (int x = 0; x < w; x++)
                begin
                    if (!pix[base + x])
                    begin
                        run = 0;
                        any_bg = 1;
                    end
                    else if (run >= 0)
                        run++;
                    rowd[base + x] = run;
                end
                run = -1;
                for (int x = w - 1; x >= 0; x--)
                begin
                    if (!pix[base + x])
                        run = 0;
                    else if (run >= 0)
                        run++;
                    if (run >= 0 && (rowd[base + x] < 0 || run < rowd[base + x]))
                        rowd[base + x] = run;
                end
            end
            for (int y = 0; y < h; y++)
            begin
                for (int x = 0; x < w; x++)
                begin
                    if (!any_bg)
                        dstore[y * w + x] = 'h20000 | 'h1FFFF;
                    else
                    begin
                        best = '1;
                        for (int yy = 0; yy < h; yy++)
                        begin
                            if (rowd[yy * w + x] < 0) continue;
                            dy = (yy > y) ? yy - y : y - yy;
                            if (manhattan)
                                cand = dy + rowd[yy * w + x];
                            else
                                cand = dy * dy + longint'(rowd[yy * w + x]) * rowd[yy * w + x];
                            if (cand < best) best = cand;
                        end
                        if (manhattan)
                            q = best << edt_pkg::FRACTION_BITS;
                        else
                            q = int_sqrt(best << (2 * edt_pkg::FRACTION_BITS));
                        if (q > 'h1FFFF) q = 'h1FFFF;
                        dstore[y * w + x] = 32'(q);
                    end
                    dvalid[y * w + x] = 1;
                end
            end
        endfunction

        function void note_item(logic m, logic fg);
            int unsigned n, p;
            dist_result_t r;
            n = pixel_count();
            // any item taken after a frame completes means its compute is done
            computing = 0;
            if (m == edt_pkg::MODE_WRITE)
            begin
                p = (load_pos >= n) ? 0 : load_pos;
                pix[p] = fg;
                p++;
                if (p >= n)
                begin
                    transform_frame();
                    computing = 1;
                    load_pos = 0;
                    read_pos = 0;
                end
                else
                    load_pos = p;
            end
            else
            begin
                p = (read_pos >= n) ? 0 : read_pos;
                r.distance = dstore[p][16:0];
                r.nobg = dstore[p][17];
                r.last = (p + 1 == n);
                pending_distances.push_back(r);
                p++;
                read_pos = (p >= n) ? 0 : p;
            end
        endfunction

        function void check_result(logic [16:0] d, logic nb, logic lf);
            dist_result_t e;
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected result distance_q8=%0d", $realtime, d);
                errors++;
                return;
            end
            e = pending_distances.pop_front();
            if (d !== e.distance)
            begin
                $display("%0t: distance_q8 expected %0d actual %0d", $realtime, e.distance, d);
                errors++;
            end
            if (nb !== e.nobg)
            begin
                $display("%0t: no_background expected %0b actual %0b", $realtime, e.nobg, nb);
                errors++;
            end
            if (lf !== e.last)
            begin
                $display("%0t: last_of_frame expected %0b actual %0b", $realtime, e.last, lf);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic        mode, is_foreground;
    logic        out_valid, out_ready;
    logic [16:0] distance_q8;
    logic        no_background, last_of_frame;

    distance_oracle oracle = new();
    bit          no_idle = 0;
    int unsigned items_sent = 0;

    exact_distance_transform u_top (.*);

    always #4 clk = ~clk;

    // Drive one item: idle gap, then hold valid until the handshake.
    task automatic send_item(logic m, logic fg);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        is_foreground <= fg;
        do @(posedge clk); while (!in_ready);
        oracle.note_item(m, fg);
        items_sent++;
    endtask

    task automatic read_result();
        if (oracle.can_read())
            send_item(edt_pkg::MODE_READ, $urandom_range(0, 1));
    endtask

    // Write a register once the block has drained and finished any compute.
    task automatic write_reg(logic [1:0] idx, int unsigned val);
        in_valid <= 1'b0;
        wait (oracle.pending_distances.size() == 0);
        @(posedge clk);
        if (oracle.computing)
        begin
            repeat (oracle.settle_cycles()) @(posedge clk);
            oracle.computing = 0;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        oracle.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic setup_frame(int unsigned w, int unsigned h, bit metric);
        write_reg(edt_pkg::REG_WIDTH, w);
        write_reg(edt_pkg::REG_HEIGHT, h);
        write_reg(edt_pkg::REG_METRIC, metric);
    endtask

    // Load pixels: background at bg_at, else foreground with density percent.
    // Interleave occasional reads of the previous frame; stop early at cut.
    task automatic load_pixels(int density, int bg_at, int cut);
        int unsigned n;
        n = oracle.pixel_count();
        for (int i = 0; i < n && i != cut; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                read_result();
            send_item(edt_pkg::MODE_WRITE,
                      (i == bg_at) ? 1'b0 : ($urandom_range(0, 99) < density));
        end
    endtask

    task automatic read_frame(int extra);
        for (int i = 0; i < oracle.pixel_count() + extra; i++)
            read_result();
    endtask

    // Response side: random stall before each result, then hold ready.
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            oracle.check_result(distance_q8, no_background, last_of_frame);
        end
    end

    initial
    begin
        #40_000_000;
        $display("exact_distance_transform verification failed");
        $finish;
    end

    initial
    begin
        int unsigned w, h;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        mode          = edt_pkg::MODE_WRITE;
        is_foreground = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small frame under both metrics, wrap on read.
        setup_frame(3, 2, 0);
        load_pixels(100, 4, -1);
        read_frame(2);
        write_reg(edt_pkg::REG_METRIC, 1);
        read_frame(0);
        load_pixels(100, 0, -1);
        read_frame(0);
        // Frame without background, then all background.
        load_pixels(100, -1, -1);
        read_frame(1);
        load_pixels(0, -1, -1);
        read_frame(0);
        // Zero sizes clamp to a single pixel.
        setup_frame(0, 0, 0);
        load_pixels(100, -1, -1);
        read_frame(1);
        load_pixels(0, -1, -1);
        read_frame(0);
        // Oversized width clamps to the widest row; oversized height to the
        // tallest column. Read back only the start of each.
        setup_frame(511, 1, 0);
        load_pixels(100, 255, -1);
        read_frame(-248);
        setup_frame(1, 511, 1);
        load_pixels(100, 255, -1);
        read_frame(-248);
        // Partial load, reads of the old frame, then a size change restarts.
        setup_frame(4, 3, 0);
        load_pixels(70, 5, -1);
        load_pixels(70, -1, 5);
        read_frame(3);
        write_reg(edt_pkg::REG_WIDTH, 4);
        load_pixels(60, -1, -1);
        read_frame(0);

        // Random: mostly complete frames of small size, some broken loads.
        while (items_sent < 650)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            setup_frame(w, h, $urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0: load_pixels(100, -1, -1);
                1: load_pixels(0, -1, -1);
                2: load_pixels(95, $urandom_range(0, w * h - 1), $urandom_range(0, w * h - 1));
                default: load_pixels($urandom_range(30, 95), -1, -1);
            endcase
            read_frame($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(edt_pkg::REG_METRIC, $urandom_range(0, 1));
                read_frame(0);
            end
        end

        in_valid <= 1'b0;
        wait (oracle.pending_distances.size() == 0);
        repeat (64) @(posedge clk);
        if (oracle.errors == 0)
            $display("exact_distance_transform verification clean");
        else
            $display("exact_distance_transform verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/edt_pkg.sv
hdl/edt_ram.sv
hdl/edt_sqrt.sv
hdl/exact_distance_transform.sv
verif/tb.sv
